### design/lrg_pkg.sv
`default_nettype none
package lrg_pkg;

  localparam int COUNT_BITS_DEF  = 22;
  localparam int OUTPUT_RATE_DEF = 48000;
  localparam int MAX_OUT         = 16;
  localparam int K_W             = $clog2(MAX_OUT + 1);
  localparam int SAMPLE_W        = 16;
  localparam int FRAC_W          = 16;
  localparam int PHASE_FRAC_W    = 32;
  localparam int RATE_W          = 16;
  localparam int CHAN_W          = 2;
  localparam int VOL_W           = 7;
  localparam int GAIN_W          = 16;
  localparam int FRAME_CNT_W     = 22;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 22;
  localparam int DVD_W           = 48;
  localparam int DVS_W           = 24;
  localparam int DIV_CNT_W       = $clog2(DVD_W);

  localparam logic [RATE_W-1:0] RATE_MIN     = RATE_W'(8000);
  localparam logic [RATE_W-1:0] RATE_MAX     = RATE_W'(48000);
  localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(48000);
  localparam logic [VOL_W-1:0]  VOL_MAX      = VOL_W'(100);
  localparam logic [VOL_W-1:0]  GAIN_SCALE   = VOL_W'(100);
  localparam logic [CHAN_W-1:0] CHAN_MONO    = CHAN_W'(1);
  localparam logic [CHAN_W-1:0] CHAN_RESET   = CHAN_W'(2);
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_RATE   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_VOLUME        = 3'd2,
    REG_GAIN_NUM      = 3'd3,
    REG_GAIN_DEN      = 3'd4,
    REG_FRAME_COUNT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_STEP_WAIT,
    ST_CHECK,
    ST_LERP,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SAT,
    ST_EMIT,
    ST_FINISH
  } lrg_state_t;

  typedef struct packed {
    logic in_load;
    logic step_start;
    logic step_load;
    logic lerp;
    logic mul1;
    logic mul2;
    logic gain_start;
    logic sat;
    logic emit;
    logic finish;
    logic ch;
  } lrg_cmd_t;

  typedef struct packed {
    logic step_ok;
    logic emit_ok;
    logic out_free;
    logic div_done;
  } lrg_sts_t;

endpackage
`default_nettype wire

### design/lrg_if.sv
`default_nettype none
interface lrg_in_if;
  import lrg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last_frame;
  modport source (output valid, left_sample, right_sample, last_frame, input ready);
  modport sink (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface lrg_out_if;
  import lrg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last_out;
  modport source (output valid, left_out, right_out, last_out, input ready);
  modport sink (input valid, left_out, right_out, last_out, output ready);
endinterface
`default_nettype wire

### design/lrg_div.sv
`default_nettype none
module lrg_div
  import lrg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : DVS_W'(rem_sh);
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### design/lrg_ctrl.sv
`default_nettype none
module lrg_ctrl
  import lrg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lrg_sts_t sts,
  output lrg_cmd_t      cmd
);

  lrg_state_t state, state_next;
  logic       ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    unique case (state)
      ST_IDLE: begin
        if (!sts.step_ok) state_next = ST_STEP;
        else if (in_valid) state_next = ST_CHECK;
      end
      ST_STEP:      state_next = ST_STEP_WAIT;
      ST_STEP_WAIT: if (sts.div_done) state_next = ST_IDLE;
      ST_CHECK:     state_next = sts.emit_ok ? ST_LERP : ST_FINISH;
      ST_LERP: begin
        state_next = ST_MUL1;
        ch_next    = 1'b0;
      end
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_DIV;
      ST_DIV:       state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (sts.div_done) state_next = ST_SAT;
      ST_SAT: begin
        if (ch) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL1;
          ch_next    = 1'b1;
        end
      end
      ST_EMIT:      if (sts.out_free) state_next = ST_CHECK;
      ST_FINISH:    state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = sts.step_ok;
        cmd.in_load = sts.step_ok && in_valid;
      end
      ST_STEP:      cmd.step_start = 1'b1;
      ST_STEP_WAIT: cmd.step_load  = sts.div_done;
      ST_LERP:      cmd.lerp       = 1'b1;
      ST_MUL1:      cmd.mul1       = 1'b1;
      ST_MUL2:      cmd.mul2       = 1'b1;
      ST_DIV:       cmd.gain_start = 1'b1;
      ST_SAT:       cmd.sat        = 1'b1;
      ST_EMIT:      cmd.emit       = sts.out_free;
      ST_FINISH:    cmd.finish     = 1'b1;
      default:      cmd            = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/lrg_datapath.sv
`default_nettype none
module lrg_datapath
  import lrg_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int OUTPUT_RATE = OUTPUT_RATE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] left_sample,
  input  wire logic signed [SAMPLE_W-1:0] right_sample,
  input  wire logic                       last_frame,
  input  wire lrg_cmd_t                   cmd,
  output lrg_sts_t                        sts,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      left_out,
  output logic signed [SAMPLE_W-1:0]      right_out,
  output logic                            last_out
);

  localparam int PW = COUNT_BITS + PHASE_FRAC_W;

  logic [RATE_W-1:0]      source_rate;
  logic [CHAN_W-1:0]      channel_count;
  logic [VOL_W-1:0]       volume_percent;
  logic [GAIN_W-1:0]      gain_numerator;
  logic [GAIN_W-1:0]      gain_denominator;
  logic [FRAME_CNT_W-1:0] output_frame_count;

  logic                   step_ok;
  logic [DVD_W-1:0]       step;
  logic [PW-1:0]          phase;
  logic [COUNT_BITS-1:0]  emitted;
  logic [COUNT_BITS-1:0]  received;
  logic [K_W-1:0]         k;

  logic signed [SAMPLE_W-1:0] prior_left, prior_right, cur_left, cur_right;
  logic                       cur_last;
  logic signed [SAMPLE_W-1:0] lerp_left, lerp_right, res_left, res_right;
  logic signed [32:0]         prod1;
  logic signed [40:0]         prod2;
  logic                       neg;

  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  idx;
  logic                   in_span;
  logic [RATE_W-1:0]      rate_c;
  logic [VOL_W-1:0]       vol_c;
  logic [GAIN_W-1:0]      den_c;
  logic [DVS_W-1:0]       den100;
  logic [DVD_W-1:0]       div_dvd;
  logic [DVS_W-1:0]       div_dvs;
  logic                   div_done;
  logic [DVD_W-1:0]       quotient;
  logic [FRAC_W-1:0]      frac;
  logic signed [SAMPLE_W-1:0] a_l, a_r, b_l, b_r, v_l, v_r, gain_in, sat_val;
  logic signed [33:0]     lp_l, lp_r;
  logic signed [40:0]     mag2;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_rate        <= RATE_RESET;
      channel_count      <= CHAN_RESET;
      volume_percent     <= VOL_MAX;
      gain_numerator     <= GAIN_W'(1);
      gain_denominator   <= GAIN_W'(1);
      output_frame_count <= FRAME_CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_RATE:   source_rate        <= cfg_data[RATE_W-1:0];
        REG_CHANNEL_COUNT: channel_count      <= cfg_data[CHAN_W-1:0];
        REG_VOLUME:        volume_percent     <= cfg_data[VOL_W-1:0];
        REG_GAIN_NUM:      gain_numerator     <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DEN:      gain_denominator   <= cfg_data[GAIN_W-1:0];
        REG_FRAME_COUNT:   output_frame_count <= cfg_data[FRAME_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign rate_c = (source_rate < RATE_MIN) ? RATE_MIN :
                  (source_rate > RATE_MAX) ? RATE_MAX : source_rate;
  assign vol_c  = (volume_percent > VOL_MAX) ? VOL_MAX : volume_percent;
  assign den_c  = (gain_denominator == '0) ? GAIN_W'(1) : gain_denominator;
  assign den100 = DVS_W'(den_c * GAIN_SCALE);

  assign count  = (COUNT_BITS'({32'd0, output_frame_count}) == '0) ? COUNT_BITS'(1)
                : COUNT_BITS'({32'd0, output_frame_count});
  assign idx     = phase[PW-1:PHASE_FRAC_W];
  assign frac    = phase[PHASE_FRAC_W-1:PHASE_FRAC_W-FRAC_W];
  assign in_span = (received != '0) && (idx < received);

  assign sts.step_ok  = step_ok;
  assign sts.emit_ok  = (k < K_W'(MAX_OUT)) && (emitted < count) && (in_span || cur_last);
  assign sts.out_free = !out_valid || out_ready;
  assign sts.div_done = div_done;

  // shared serial divider: phase step and gain
  assign mag2    = neg ? -prod2 : prod2;
  assign div_dvd = cmd.step_start ? {rate_c, 32'd0} : DVD_W'(mag2[39:0]);
  assign div_dvs = cmd.step_start ? DVS_W'(OUTPUT_RATE) : den100;

  lrg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.step_start || cmd.gain_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ok <= 1'b0;
    end else if (cfg_we && cfg_index == REG_SOURCE_RATE) begin
      step_ok <= 1'b0;
    end else if (cmd.step_load) begin
      step_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_load) step <= quotient;
  end

  // interpolation
  assign a_l = in_span ? prior_left  : cur_left;
  assign a_r = in_span ? prior_right : cur_right;
  assign b_l = cur_left;
  assign b_r = cur_right;
  assign lp_l = ($signed({b_l[15], b_l}) - $signed({a_l[15], a_l})) * $signed({1'b0, frac});
  assign lp_r = ($signed({b_r[15], b_r}) - $signed({a_r[15], a_r})) * $signed({1'b0, frac});
  assign v_l  = a_l + SAMPLE_W'(lp_l >>> FRAC_W);
  assign v_r  = a_r + SAMPLE_W'(lp_r >>> FRAC_W);

  assign gain_in = cmd.ch ? lerp_right : lerp_left;

  always_comb begin
    if (neg) begin
      sat_val = (quotient > DVD_W'(32768)) ? SAT_MIN : SAMPLE_W'(-quotient);
    end else begin
      sat_val = (quotient > DVD_W'(32767)) ? SAT_MAX : SAMPLE_W'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cur_left  <= left_sample;
      cur_right <= (channel_count == CHAN_MONO) ? left_sample : right_sample;
      cur_last  <= last_frame;
    end
    if (cmd.lerp) begin
      lerp_left  <= v_l;
      lerp_right <= v_r;
    end
    if (cmd.mul1) prod1 <= gain_in * $signed({1'b0, gain_numerator});
    if (cmd.mul2) begin
      prod2 <= prod1 * $signed({1'b0, vol_c});
      neg   <= prod1[32];
    end
    if (cmd.sat && !cmd.ch) res_left <= sat_val;
    if (cmd.sat && cmd.ch) res_right <= sat_val;
  end

  // clip state
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_left  <= '0;
      prior_right <= '0;
      phase       <= '0;
      emitted     <= '0;
      received    <= '0;
      k           <= '0;
    end else begin
      if (cmd.in_load) k <= '0;
      if (cmd.emit) begin
        emitted <= emitted + 1'b1;
        phase   <= phase + PW'(step);
        k       <= k + 1'b1;
      end
      if (cmd.finish) begin
        if (cur_last) begin
          prior_left  <= '0;
          prior_right <= '0;
          phase       <= '0;
          emitted     <= '0;
          received    <= '0;
        end else begin
          prior_left  <= cur_left;
          prior_right <= cur_right;
          received    <= received + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out  <= res_left;
      right_out <= res_right;
      last_out  <= (emitted + 1'b1) == count;
    end
  end

endmodule
`default_nettype wire

### design/linear_resampler_with_gain.sv
`default_nettype none
// channel    | dir | payload                                   | transfer
// frames     | in  | left_sample, right_sample, last_frame     | valid & ready
// resampled  | out | left_out, right_out, last_out             | valid & ready
// cfg        | in  | cfg_index, cfg_data                       | cfg_we
//
// after reset or a source_rate write the phase step is worked out on the
// serial divider before the first frame is taken
// each output frame takes two gain divisions on the shared
// one-bit-per-cycle divider plus check, interpolate, multiply,
// saturate and emit steps
// a source frame passes the idle, check and finish states plus the steps of each output it emits (0 to 16)
// a stalled result waits in the output register; emission waits only when a
// second result is ready before the first is taken
module linear_resampler_with_gain
  import lrg_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int OUTPUT_RATE = OUTPUT_RATE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lrg_in_if.sink                     frames,
  lrg_out_if.source                  resampled,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  lrg_cmd_t cmd;
  lrg_sts_t sts;

  lrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frames.valid),
    .in_ready (frames.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrg_datapath #(
    .COUNT_BITS  (COUNT_BITS),
    .OUTPUT_RATE (OUTPUT_RATE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_sample  (frames.left_sample),
    .right_sample (frames.right_sample),
    .last_frame   (frames.last_frame),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (resampled.valid),
    .out_ready    (resampled.ready),
    .left_out     (resampled.left_out),
    .right_out    (resampled.right_out),
    .last_out     (resampled.last_out)
  );

endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench;
  import lrg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CNT_MASK   = (64'd1 << FRAME_CNT_W) - 1;
  localparam longint unsigned PHASE_MASK = (64'd1 << (FRAME_CNT_W + 32)) - 1;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE      = 2000;
  localparam int ITEM_GOAL   = 260;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } out_frame_t;

  typedef struct {
    bit             is_cfg;
    cfg_reg_t       idx;
    int             val;
    shortint        left;
    shortint        right;
    bit             last;
    bit             typed;
    out_frame_t     exp;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lrg_in_if  fr();
  lrg_out_if rs();

  linear_resampler_with_gain u_dut (
    .clk       (clk),
    .rst       (rst),
    .frames    (fr),
    .resampled (rs),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of registers and clip state
  longint unsigned rate_reg, chan_reg, vol_reg, num_reg, den_reg, count_reg;
  int              prior_l, prior_r;
  longint unsigned phase_acc, emitted, received;

  out_frame_t expected_frames[$];
  row_t       tbl[$];
  int         errors;
  int         cycles;
  int         items_sent;
  bit         hold_req;
  bit         hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void clear_clip();
    prior_l   = 0;
    prior_r   = 0;
    phase_acc = 0;
    emitted   = 0;
    received  = 0;
  endfunction

  function automatic void shadow_write(cfg_reg_t idx, longint unsigned v);
    case (idx)
      REG_SOURCE_RATE:   rate_reg  = v & 16'hffff;
      REG_CHANNEL_COUNT: chan_reg  = v & 2'h3;
      REG_VOLUME:        vol_reg   = v & 7'h7f;
      REG_GAIN_NUM:      num_reg   = v & 16'hffff;
      REG_GAIN_DEN:      den_reg   = v & 16'hffff;
      REG_FRAME_COUNT:   count_reg = v & CNT_MASK;
      default: ;
    endcase
  endfunction

  function automatic int interpolate(int a, int b, int frac);
    longint p;
    p = longint'(b - a) * longint'(frac);
    return a + int'(p >>> 16);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] apply_gain(int s);
    longint vol, den, t;
    vol = (vol_reg > 100) ? 100 : longint'(vol_reg);
    den = (den_reg == 0) ? 1 : longint'(den_reg);
    t = (longint'(s) * longint'(num_reg) * vol) / (den * 100);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[SAMPLE_W-1:0];
  endfunction

  // works out the output frames one source frame produces
  function automatic void resample_frame(logic signed [15:0] l_in, logic signed [15:0] r_in,
                                         logic last, bit store);
    int cl, cr, al, ar, bl, br, k, frac;
    longint unsigned n, cnt, rate, step, idx;
    out_frame_t o;
    cl = l_in;
    cr = (chan_reg == CHAN_MONO) ? cl : int'(r_in);
    n = received & CNT_MASK;
    cnt = count_reg & CNT_MASK;
    if (cnt == 0) cnt = 1;
    rate = rate_reg;
    if (rate < RATE_MIN) rate = RATE_MIN;
    if (rate > RATE_MAX) rate = RATE_MAX;
    step = (rate << 32) / OUTPUT_RATE_DEF;
    k = 0;
    while (k < MAX_OUT && emitted < cnt) begin
      idx = phase_acc >> 32;
      frac = int'((phase_acc >> 16) & 16'hffff);
      if (n > 0 && idx < n) begin
        al = prior_l; ar = prior_r; bl = cl; br = cr;
      end else if (last) begin
        al = cl; ar = cr; bl = cl; br = cr;
      end else begin
        break;
      end
      emitted = (emitted + 1) & CNT_MASK;
      o.left  = apply_gain(interpolate(al, bl, frac));
      o.right = apply_gain(interpolate(ar, br, frac));
      o.last  = (emitted == cnt);
      if (store) expected_frames.push_back(o);
      phase_acc = (phase_acc + step) & PHASE_MASK;
      k++;
    end
    prior_l = cl;
    prior_r = cr;
    received = (n + 1) & CNT_MASK;
    if (last) clear_clip();
  endfunction

  task automatic write_reg(cfg_reg_t idx, int v);
    wait (expected_frames.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_write(idx, longint'(v));
    @(posedge clk);
  endtask

  // drives one frame and holds it until the transfer happens; valid is left high
  task automatic send_frame(shortint l, shortint r, bit last, bit typed, out_frame_t exp);
    fr.valid        <= 1'b1;
    fr.left_sample  <= l;
    fr.right_sample <= r;
    fr.last_frame   <= last;
    do @(posedge clk); while (!fr.ready);
    resample_frame(l, r, last, !typed);
    if (typed) expected_frames.push_back(exp);
    items_sent++;
  endtask

  task automatic gap_after(int gap);
    if (gap > 0) begin
      fr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void add_cfg(cfg_reg_t idx, int v);
    row_t r;
    r = '{idx: REG_SOURCE_RATE, default: 0};
    r.is_cfg = 1;
    r.idx = idx;
    r.val = v;
    tbl.push_back(r);
  endfunction

  function automatic void add_frame(shortint l, shortint r, bit last);
    row_t x;
    x = '{idx: REG_SOURCE_RATE, default: 0};
    x.left = l;
    x.right = r;
    x.last = last;
    tbl.push_back(x);
  endfunction

  function automatic void add_typed(shortint l, shortint r, bit last, out_frame_t e);
    row_t x;
    x = '{idx: REG_SOURCE_RATE, default: 0};
    x.left = l;
    x.right = r;
    x.last = last;
    x.typed = 1;
    x.exp = e;
    tbl.push_back(x);
  endfunction

  function automatic shortint rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return shortint'($urandom_range(0, 15)) - 8;
      default: return shortint'($urandom);
    endcase
  endfunction

  // checker on the output channel
  always @(posedge clk) begin
    out_frame_t e;
    if (!rst && rs.valid && rs.ready) begin
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output frame %0d %0d last=%0b", rs.left_out, rs.right_out,
                   rs.last_out);
      end else begin
        e = expected_frames.pop_front();
        if (e.left !== rs.left_out || e.right !== rs.right_out || e.last !== rs.last_out) begin
          errors++;
          if (errors <= 10)
            $display("output frame mismatch: expected %0d %0d last=%0b, got %0d %0d last=%0b",
                     e.left, e.right, e.last, rs.left_out, rs.right_out, rs.last_out);
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int len, mode;
    rs.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_req && !hold_done) begin
        rs.ready <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_done = 1;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 300);
      repeat (len) begin
        case (mode)
          0: rs.ready <= 1'b1;
          1: rs.ready <= $urandom_range(0, 1);
          2: rs.ready <= ($urandom_range(0, 7) == 0);
          default: rs.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    out_frame_t e;
    int burst, clips, clip_len, gap, d;
    longint unsigned crate, cnt;
    bit no_gaps;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fr.valid = 1'b0;
    fr.left_sample = '0;
    fr.right_sample = '0;
    fr.last_frame = 1'b0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    hold_req = 0;
    hold_done = 0;
    rate_reg = RATE_RESET;
    chan_reg = CHAN_RESET;
    vol_reg = 100;
    num_reg = 1;
    den_reg = 1;
    count_reg = 1;
    clear_clip();

    // defaults after reset: single-frame clips pass samples straight through
    e = '{left: 16'sh7fff, right: 16'sh8000, last: 1'b1};
    add_typed(16'sh7fff, 16'sh8000, 1, e);
    e = '{left: 16'sh8000, right: 16'sh7fff, last: 1'b1};
    add_typed(16'sh8000, 16'sh7fff, 1, e);
    e = '{left: 16'sh0000, right: 16'sh0000, last: 1'b1};
    add_typed(16'sh0000, 16'sh0000, 1, e);
    // rate below range and zero frame count, then a real upsampled clip
    add_cfg(REG_SOURCE_RATE, 4000);
    add_cfg(REG_FRAME_COUNT, 0);
    add_frame(1000, -1000, 1);
    add_cfg(REG_FRAME_COUNT, 12);
    add_frame(1000, -1000, 0);
    add_frame(-2000, 3000, 1);
    // rate above range, mono, volume above 100, zero denominator, saturation
    add_cfg(REG_SOURCE_RATE, 60000);
    add_cfg(REG_CHANNEL_COUNT, 1);
    add_cfg(REG_VOLUME, 127);
    add_cfg(REG_GAIN_DEN, 0);
    add_cfg(REG_GAIN_NUM, 3);
    add_frame(20000, 5, 0);
    add_frame(100, -7, 1);
    // result cap on the tail of the clip
    add_cfg(REG_CHANNEL_COUNT, 2);
    add_cfg(REG_VOLUME, 50);
    add_cfg(REG_GAIN_NUM, 65535);
    add_cfg(REG_GAIN_DEN, 65535);
    add_cfg(REG_FRAME_COUNT, 40);
    add_frame(-32768, 32767, 0);
    add_frame(32767, -32768, 0);
    add_frame(12345, -12345, 1);
    // count reached early
    add_cfg(REG_FRAME_COUNT, 1);
    add_frame(500, 600, 0);
    add_frame(700, 800, 0);
    add_frame(900, 1000, 0);
    add_frame(-1, -2, 1);
    // largest frame count, zero volume
    add_cfg(REG_FRAME_COUNT, 4194303);
    add_cfg(REG_VOLUME, 0);
    add_frame(4321, -4321, 0);
    add_frame(-32768, -32768, 1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tbl[i]) begin
      if (tbl[i].is_cfg) begin
        fr.valid <= 1'b0;
        write_reg(tbl[i].idx, tbl[i].val);
      end else begin
        send_frame(tbl[i].left, tbl[i].right, tbl[i].last, tbl[i].typed, tbl[i].exp);
        gap_after($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
      end
    end
    fr.valid <= 1'b0;

    while (items_sent < ITEM_GOAL) begin
      fr.valid <= 1'b0;
      case ($urandom_range(0, 5))
        0: d = RATE_MIN;
        1: d = RATE_MAX;
        2: d = $urandom_range(0, 65535);
        default: d = $urandom_range(8000, 48000);
      endcase
      write_reg(REG_SOURCE_RATE, d);
      write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 3));
      write_reg(REG_VOLUME, $urandom_range(0, 7) == 0 ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 100));
      d = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 4000);
      write_reg(REG_GAIN_DEN, d);
      case ($urandom_range(0, 4))
        0: write_reg(REG_GAIN_NUM, $urandom_range(0, 65535));
        1: write_reg(REG_GAIN_NUM, 65535);
        default: write_reg(REG_GAIN_NUM, $urandom_range(1, d == 0 ? 1 : d));
      endcase
      clip_len = $urandom_range(1, 10);
      crate = rate_reg < RATE_MIN ? RATE_MIN : (rate_reg > RATE_MAX ? RATE_MAX : rate_reg);
      cnt = (longint'(clip_len) * 48000 + crate / 2) / crate;
      case ($urandom_range(0, 7))
        0: cnt = $urandom_range(0, 4194303);
        1: cnt = cnt + $urandom_range(0, 4);
        2: cnt = (cnt > 2) ? cnt - 2 : 0;
        default: ;
      endcase
      write_reg(REG_FRAME_COUNT, int'(cnt));
      if (!hold_req && items_sent > 60) hold_req = 1;
      no_gaps = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(1, 10);
      clips = $urandom_range(1, 3);
      repeat (clips) begin
        // an occasional broken clip with a stray length
        d = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : clip_len;
        for (int f = 0; f < d; f++) begin
          send_frame(rand_sample(), rand_sample(), f == d - 1, 0, '0);
          if (no_gaps) begin
            gap = 0;
          end else if (burst > 0) begin
            burst--;
            gap = 0;
          end else begin
            burst = $urandom_range(1, 10);
            gap = $urandom_range(1, 40);
          end
          gap_after(gap);
        end
      end
    end
    fr.valid <= 1'b0;

    wait (expected_frames.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
